// File: rtl/core/dsu_pkg.sv
// dsu_pkg: shared constants and operation codes for the disjoint-set block.
// No dependencies; used by dsu_mem, dsu_reduce and disjoint_set_union.
package dsu_pkg;

  localparam int DSU_NODES = 1024;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;

  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_JOIN  = 2'd1,
    OP_FIND  = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

endpackage

// File: rtl/core/disjoint_set_union.sv
// disjoint_set_union: union-find by size with path compression over NODES elements.
// Sequencer, component count and output register; uses dsu_mem, dsu_reduce, dsu_pkg.
//
//   port group   dir  contents (low bit first)
//   cfg_*        in   cfg_wr_data: node_count[10:0]
//   in_*         in   in_tuser: op[1:0]; in_tdata: node_a[9:0], node_b[19:10]
//   out_*        out  out_tdata: root[9:0], merged[10], components[21:11]
//
// Find folds the indexes, then walks from node_a to its root and compresses the path;
// Join does so for node_a and node_b, then links the smaller set under the larger
// when the sets differ. Depth stays at most log2(NODES); one table read per walk step
// sets the pace.
// Clear and reset sweep the table, one entry a cycle.
// A result waiting on out_tready holds the next item at its last step only.
module disjoint_set_union #(
  parameter int NODES = dsu_pkg::DSU_NODES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,  // node_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // node_a[9:0], node_b[19:10], zero fill
  input  logic [1:0]  in_tuser,     // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata     // root[9:0], merged[10], components[21:11], zero fill
);

  localparam int IW = $clog2(NODES);
  localparam int SW = $clog2(NODES + 1);
  localparam int EW = IW + SW;
  localparam int RW = dsu_pkg::IDX_W;
  localparam int CW = dsu_pkg::CNT_W;
  localparam logic [SW-1:0] SIZE_ONE = SW'(1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_RED,
    S_WISS,
    S_WCHK,
    S_CCHK,
    S_PEND,
    S_LINK,
    S_FIN
  } state_t;

  state_t          state_r, state_nxt;
  dsu_pkg::op_t    op_r, op_nxt;
  logic [IW-1:0]   cur_r, cur_nxt;
  logic [IW-1:0]   root_r, root_nxt;
  logic [SW-1:0]   rsize_r, rsize_nxt;
  logic [IW-1:0]   ra_r, ra_nxt;
  logic [SW-1:0]   sa_r, sa_nxt;
  logic            phase_r, phase_nxt;
  logic [IW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic            clr_emit_r, clr_emit_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   node_count_r, node_count_nxt;
  logic [IW-1:0]   res_root_r, res_root_nxt;
  logic            res_merged_r, res_merged_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [RW-1:0]   out_root_r, out_root_nxt;
  logic            out_merged_r, out_merged_nxt;
  logic [CW-1:0]   out_count_r, out_count_nxt;

  logic            mem_rd_en;
  logic [IW-1:0]   mem_rd_addr;
  logic [EW-1:0]   mem_rd_data;
  logic            mem_wr_en;
  logic [IW-1:0]   mem_wr_addr;
  logic [EW-1:0]   mem_wr_data;

  logic            red_start;
  logic            red_done;
  logic [IW-1:0]   red_a;
  logic [IW-1:0]   red_b;

  logic            in_acc;
  dsu_pkg::op_t    in_op;
  logic [IW-1:0]   rd_parent;
  logic [SW-1:0]   rd_size;
  logic [IW-1:0]   start_node;
  logic            swap;
  logic [IW-1:0]   big;
  logic [IW-1:0]   small_root;
  logic [SW-1:0]   small_size;
  logic [SW-1:0]   size_sum;

  dsu_mem #(
    .DEPTH (NODES)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  dsu_reduce #(
    .NODES (NODES)
  ) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .a_raw (in_tdata[9:0]),
    .b_raw (in_tdata[19:10]),
    .done  (red_done),
    .a_idx (red_a),
    .b_idx (red_b)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_op      = dsu_pkg::op_t'(in_tuser);
  assign rd_parent  = mem_rd_data[IW-1:0];
  assign rd_size    = mem_rd_data[EW-1:IW];
  assign start_node = phase_r ? red_b : red_a;

  assign swap       = (sa_r < rsize_r);
  assign big        = swap ? root_r : ra_r;
  assign small_root = swap ? ra_r : root_r;
  assign small_size = swap ? sa_r : rsize_r;
  assign size_sum   = sa_r + rsize_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cur_nxt        = cur_r;
    root_nxt       = root_r;
    rsize_nxt      = rsize_r;
    ra_nxt         = ra_r;
    sa_nxt         = sa_r;
    phase_nxt      = phase_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_emit_nxt   = clr_emit_r;
    count_nxt      = count_r;
    node_count_nxt = cfg_wr_en ? cfg_wr_data : node_count_r;
    res_root_nxt   = res_root_r;
    res_merged_nxt = res_merged_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_root_nxt   = out_root_r;
    out_merged_nxt = out_merged_r;
    out_count_nxt  = out_count_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = cur_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = cur_r;
    mem_wr_data    = {rd_size, root_r};
    red_start      = 1'b0;

    case (state_r)
      S_CLR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt_r;
        mem_wr_data = {SIZE_ONE, clr_cnt_r};
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          clr_cnt_nxt = '0;
          state_nxt   = clr_emit_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_op;
          phase_nxt      = 1'b0;
          res_root_nxt   = '0;
          res_merged_nxt = 1'b0;
          case (in_op)
            dsu_pkg::OP_CLEAR: begin
              count_nxt    = node_count_r;
              clr_cnt_nxt  = '0;
              clr_emit_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            dsu_pkg::OP_JOIN, dsu_pkg::OP_FIND: begin
              red_start = 1'b1;
              state_nxt = S_RED;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_RED: begin
        if (red_done) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = red_a;
          cur_nxt     = red_a;
          state_nxt   = S_WCHK;
        end
      end
      S_WISS: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = start_node;
        cur_nxt     = start_node;
        state_nxt   = S_WCHK;
      end
      S_WCHK: begin
        if (rd_parent == cur_r) begin
          root_nxt  = cur_r;
          rsize_nxt = rd_size;
          if (start_node == cur_r) begin
            state_nxt = S_PEND;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = start_node;
            cur_nxt     = start_node;
            state_nxt   = S_CCHK;
          end
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = rd_parent;
          cur_nxt     = rd_parent;
        end
      end
      S_CCHK: begin
        // point the node at the root; its stored size is kept
        mem_wr_en   = 1'b1;
        mem_wr_addr = cur_r;
        mem_wr_data = {rd_size, root_r};
        if (rd_parent == root_r) begin
          state_nxt = S_PEND;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = rd_parent;
          cur_nxt     = rd_parent;
        end
      end
      S_PEND: begin
        if (!phase_r) begin
          if (op_r == dsu_pkg::OP_JOIN) begin
            ra_nxt    = root_r;
            sa_nxt    = rsize_r;
            phase_nxt = 1'b1;
            state_nxt = S_WISS;
          end else begin
            res_root_nxt   = root_r;
            res_merged_nxt = 1'b0;
            state_nxt      = S_FIN;
          end
        end else if (ra_r == root_r) begin
          res_root_nxt   = ra_r;
          res_merged_nxt = 1'b0;
          state_nxt      = S_FIN;
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = small_root;
          mem_wr_data = {small_size, big};
          ra_nxt      = big;
          sa_nxt      = size_sum;
          state_nxt   = S_LINK;
        end
      end
      S_LINK: begin
        mem_wr_en      = 1'b1;
        mem_wr_addr    = ra_r;
        mem_wr_data    = {sa_r, ra_r};
        count_nxt      = (count_r != '0) ? count_r - 1'b1 : count_r;
        res_root_nxt   = ra_r;
        res_merged_nxt = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_root_nxt   = RW'(res_root_r);
          out_merged_nxt = res_merged_r;
          out_count_nxt  = count_r;
          clr_emit_nxt   = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      clr_emit_r   <= 1'b0;
      phase_r      <= 1'b0;
      count_r      <= dsu_pkg::NODE_COUNT_RESET;
      node_count_r <= dsu_pkg::NODE_COUNT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_emit_r   <= clr_emit_nxt;
      phase_r      <= phase_nxt;
      count_r      <= count_nxt;
      node_count_r <= node_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    cur_r        <= cur_nxt;
    root_r       <= root_nxt;
    rsize_r      <= rsize_nxt;
    ra_r         <= ra_nxt;
    sa_r         <= sa_nxt;
    res_root_r   <= res_root_nxt;
    res_merged_r <= res_merged_nxt;
    out_root_r   <= out_root_nxt;
    out_merged_r <= out_merged_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_count_r, out_merged_r, out_root_r};

  // no table entry is read and written in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
    else $error("table read and write collide");

  // the component count grows only through a clear
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && (in_op == dsu_pkg::OP_CLEAR)) |=> (count_r <= $past(count_r)))
    else $error("component count rose without clear");

  // folded indexes stay inside the table
  assert property (@(posedge clk) disable iff (!rst_n)
    red_done |-> ((red_a <= LAST_IDX) && (red_b <= LAST_IDX)))
    else $error("index fold out of range");

  // a result beat is raised only by the finishing step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside finish");

endmodule

// File: rtl/core/dsu_mem.sv
// dsu_mem: node table, one entry per element holding {set size, parent}.
// One write and one registered read per cycle. Depends on dsu_pkg.
module dsu_mem #(
  parameter int DEPTH = dsu_pkg::DSU_NODES,
  localparam int AW = $clog2(DEPTH),
  localparam int SW = $clog2(DEPTH + 1),
  localparam int DW = AW + SW
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/dsu_reduce.sv
// dsu_reduce: folds both raw element indexes into the range of the table.
// Truncation when NODES is a power of two or at least 2**RW, else a registered reciprocal
// multiply followed by a registered subtract. Depends on dsu_pkg.
module dsu_reduce #(
  parameter int NODES = dsu_pkg::DSU_NODES,
  localparam int IW = $clog2(NODES),
  localparam int RW = dsu_pkg::IDX_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [RW-1:0] a_raw,
  input  logic [RW-1:0] b_raw,
  output logic          done,
  output logic [IW-1:0] a_idx,
  output logic [IW-1:0] b_idx
);

  logic done_r;

  assign done = done_r;

  generate
    if ((NODES >= (1 << RW)) || (NODES == (1 << IW))) begin : g_direct
      logic [IW-1:0] a_r;
      logic [IW-1:0] b_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          a_r <= IW'(a_raw);
          b_r <= IW'(b_raw);
        end
      end

      assign a_idx = a_r;
      assign b_idx = b_r;
    end else begin : g_recip
      localparam int SH = RW + IW;
      localparam int MW = RW + 1;
      localparam int PW = RW + MW;
      localparam logic [MW-1:0] MAGIC = MW'(((1 << SH) + NODES - 1) / NODES);
      localparam logic [RW-1:0] DIVC  = RW'(NODES);

      logic [RW-1:0] va_r;
      logic [RW-1:0] vb_r;
      logic [RW-1:0] qa_r;
      logic [RW-1:0] qb_r;
      logic          s1_r;
      logic [PW-1:0] prod_a;
      logic [PW-1:0] prod_b;
      logic [IW-1:0] a_r;
      logic [IW-1:0] b_r;

      // quotient by reciprocal multiply, exact for every index of RW bits
      assign prod_a = PW'(a_raw) * PW'(MAGIC);
      assign prod_b = PW'(b_raw) * PW'(MAGIC);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          s1_r   <= 1'b0;
          done_r <= 1'b0;
        end else begin
          s1_r   <= start;
          done_r <= s1_r;
        end
        if (start) begin
          va_r <= a_raw;
          vb_r <= b_raw;
          qa_r <= RW'(prod_a >> SH);
          qb_r <= RW'(prod_b >> SH);
        end
        if (s1_r) begin
          a_r <= IW'(va_r - RW'(qa_r * DIVC));
          b_r <= IW'(vb_r - RW'(qb_r * DIVC));
        end
      end

      assign a_idx = a_r;
      assign b_idx = b_r;
    end
  endgenerate

endmodule
